// ===== hw/rtl/asmr_pkg.sv =====
`default_nettype none

package asmr_pkg;

    // Sizes of the datapath.
    localparam int MAX_DELAY  = 8192;
    localparam int DELAY_AW   = $clog2(MAX_DELAY);
    localparam int RAMP_W     = DELAY_AW + 1;
    localparam int MAX_BLOCK  = 64;
    localparam int BLOCK_W    = $clog2(MAX_BLOCK) + 1;
    localparam int PHASE_W    = $clog2(MAX_BLOCK);
    localparam int GAIN_FRAC  = 10;
    localparam int GAIN_ONE   = 1 << GAIN_FRAC;
    localparam int GAIN_W     = GAIN_FRAC + 1;
    localparam int ELAPSED_W  = 17;
    localparam int SAMPLE_W   = 16;
    localparam int EXTRA_W    = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_AW     = 2;
    localparam int DIV_CW     = $clog2(GAIN_FRAC + 1);

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_SILENCE  = 2'd0;
    localparam mode_t MODE_FADE_IN  = 2'd1;
    localparam mode_t MODE_PASS     = 2'd2;
    localparam mode_t MODE_FADE_OUT = 2'd3;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_FLUSH  = 2'd1;
    localparam logic [1:0] CMD_RESET  = 2'd2;

    localparam logic [CFG_AW-1:0] REG_RAMP  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_EXTRA = 2'd1;
    localparam logic [CFG_AW-1:0] REG_BLOCK = 2'd2;

    // Request into the gain divider: quotient = floor(num * GAIN_ONE / den), num < den.
    typedef struct packed {
        logic                start;
        logic [DELAY_AW-1:0] num;
        logic [RAMP_W-1:0]   den;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [GAIN_FRAC-1:0] quotient;
    } div_rsp_t;

    // One read-modify-write of the delay line.
    typedef struct packed {
        logic                en;
        logic [DELAY_AW-1:0] addr;
        logic [SAMPLE_W-1:0] wdata;
    } line_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/asmr_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module asmr_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire asmr_pkg::div_req_t req,
    output asmr_pkg::div_rsp_t     rsp
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [asmr_pkg::DIV_CW-1:0]       cnt_reg, cnt_next;
    logic [asmr_pkg::RAMP_W-1:0]       rem_reg, rem_next;
    logic [asmr_pkg::RAMP_W-1:0]       den_reg, den_next;
    logic [asmr_pkg::GAIN_FRAC-1:0]    quo_reg, quo_next;
    logic [asmr_pkg::RAMP_W:0]         shifted;
    logic [asmr_pkg::RAMP_W:0]         diff;
    logic                              fits;

    always_comb
    begin
        shifted   = {rem_reg, 1'b0};
        diff      = shifted - {1'b0, den_reg};
        fits      = shifted >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = {1'b0, req.num};
            den_next  = req.den;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[asmr_pkg::RAMP_W-1:0] : shifted[asmr_pkg::RAMP_W-1:0];
            quo_next = {quo_reg[asmr_pkg::GAIN_FRAC-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == asmr_pkg::DIV_CW'(asmr_pkg::GAIN_FRAC - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/asmr_line.sv =====
`default_nettype none

// Delay line memory. Reads return the old entry (read before write). Entries are
// always written as a prefix from address zero, so a fill count marks what has
// never been written; such entries read as silence.
module asmr_line (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire asmr_pkg::line_req_t               req,
    output logic [asmr_pkg::SAMPLE_W-1:0]          rdata
);

    logic [asmr_pkg::SAMPLE_W-1:0] mem [asmr_pkg::MAX_DELAY];
    logic [asmr_pkg::SAMPLE_W-1:0] rd_reg;
    logic [asmr_pkg::RAMP_W-1:0]   fill_reg, fill_next;
    logic                          blank_reg, blank_next;
    logic                          unwritten;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            rd_reg        <= mem[req.addr];
            mem[req.addr] <= req.wdata;
        end
    end

    always_comb
    begin
        unwritten  = {1'b0, req.addr} >= fill_reg;
        fill_next  = fill_reg;
        blank_next = blank_reg;
        if (req.en)
        begin
            blank_next = unwritten;
            if ({1'b0, req.addr} == fill_reg)
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            blank_reg <= 1'b1;
        end
        else
        begin
            fill_reg  <= fill_next;
            blank_reg <= blank_next;
        end
    end

    assign rdata = blank_reg ? '0 : rd_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/audio_soft_mute_ramp.sv =====
`default_nettype none

// Channel  Signals                                      Carries
// -------  -------------------------------------------  ----------------------------------
// item     item_valid, item_stall, command, sample_in   one command with its audio sample
// result   result_valid, result_stall, sample_out,      one delayed, gained audio sample
//          burst_last, ramp_mode
// config   cfg_we, cfg_index, cfg_data                  register writes, no read-back
//
// A sample transfer passes through acceptance, one delay line read-modify-write and
// the loading of the output register. At the first sample of a block in fade-in,
// and on a flush that starts part way into the ramp, the gain divider runs first,
// one quotient bit per cycle. A flush outside silence then alternates line access
// and emit for each result, as the delay line has a single read-write port.
// Reset clears the mode, counters and the delay line fill count; no clearing pass.
// A stalled result holds the output register, and the sequencer waits in front of it.
module audio_soft_mute_ramp (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 item_valid,
    output logic                                      item_stall,
    input  wire logic [1:0]                           command,
    input  wire logic signed [asmr_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                      result_valid,
    input  wire logic                                 result_stall,
    output logic signed [asmr_pkg::SAMPLE_W-1:0]      sample_out,
    output logic                                      burst_last,
    output logic [1:0]                                ramp_mode,
    input  wire logic                                 cfg_we,
    input  wire logic [asmr_pkg::CFG_AW-1:0]          cfg_index,
    input  wire logic [asmr_pkg::CFG_W-1:0]           cfg_data
);

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DIV    = 4'b0010,
        ST_ACCESS = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [asmr_pkg::RAMP_W-1:0]   ramp_reg;
    logic [asmr_pkg::EXTRA_W-1:0]  extra_reg;
    logic [asmr_pkg::BLOCK_W-1:0]  block_reg;

    // Ramp state.
    asmr_pkg::mode_t                 mode_reg, mode_next;
    logic [asmr_pkg::ELAPSED_W-1:0]  elapsed_reg, elapsed_next;
    logic [asmr_pkg::GAIN_W-1:0]     gain_reg, gain_next;
    logic [asmr_pkg::PHASE_W-1:0]    phase_reg, phase_next;
    logic [asmr_pkg::DELAY_AW-1:0]   ptr_reg, ptr_next;
    logic [asmr_pkg::PHASE_W-1:0]    burst_cnt_reg, burst_cnt_next;

    // Captured item.
    logic [1:0]                      cmd_reg, cmd_next;
    logic [asmr_pkg::SAMPLE_W-1:0]   sample_reg, sample_next;

    // Output register.
    logic                            out_valid_reg, out_valid_next;
    logic [asmr_pkg::SAMPLE_W-1:0]   out_sample_reg, out_sample_next;
    logic                            out_last_reg, out_last_next;
    asmr_pkg::mode_t                 out_mode_reg, out_mode_next;

    // Effective register values and helpers.
    logic [asmr_pkg::RAMP_W-1:0]     ramp_eff;
    logic [asmr_pkg::BLOCK_W-1:0]    block_eff;
    logic                            item_take;
    logic                            out_free;
    logic [asmr_pkg::ELAPSED_W-1:0]  flush_el;
    logic [asmr_pkg::ELAPSED_W:0]    flush_sum;
    logic [asmr_pkg::ELAPSED_W-1:0]  flush_sat;
    logic [asmr_pkg::ELAPSED_W-1:0]  step_el;
    logic [asmr_pkg::ELAPSED_W-1:0]  silence_len;
    logic [asmr_pkg::DELAY_AW-1:0]   addr_now;
    logic [asmr_pkg::RAMP_W-1:0]     addr_inc;
    logic [asmr_pkg::BLOCK_W-1:0]    phase_inc;
    logic [asmr_pkg::BLOCK_W-1:0]    burst_inc;

    // Gain multiply with rounding to nearest, ties upward, no dither.
    logic [asmr_pkg::SAMPLE_W-1:0]   line_data;
    logic signed [asmr_pkg::SAMPLE_W+asmr_pkg::GAIN_W:0]   product;
    logic signed [asmr_pkg::SAMPLE_W+asmr_pkg::GAIN_W:0]   rounded;
    logic signed [asmr_pkg::SAMPLE_W+1:0]                   scaled;
    logic [asmr_pkg::SAMPLE_W-1:0]                          gained;

    asmr_pkg::div_req_t  div_req;
    asmr_pkg::div_rsp_t  div_rsp;
    asmr_pkg::line_req_t line_req;

    asmr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    asmr_line u_line (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (line_req),
        .rdata (line_data)
    );

    // Out-of-range register values are clamped to the usable span.
    always_comb
    begin
        if (ramp_reg == '0)
            ramp_eff = asmr_pkg::RAMP_W'(1);
        else if (ramp_reg > asmr_pkg::RAMP_W'(asmr_pkg::MAX_DELAY))
            ramp_eff = asmr_pkg::RAMP_W'(asmr_pkg::MAX_DELAY);
        else
            ramp_eff = ramp_reg;

        if (block_reg == '0)
            block_eff = asmr_pkg::BLOCK_W'(1);
        else if (block_reg > asmr_pkg::BLOCK_W'(asmr_pkg::MAX_BLOCK))
            block_eff = asmr_pkg::BLOCK_W'(asmr_pkg::MAX_BLOCK);
        else
            block_eff = block_reg;
    end

    always_comb
    begin
        product = $signed(line_data) * $signed({1'b0, gain_reg});
        rounded = product + (asmr_pkg::SAMPLE_W + asmr_pkg::GAIN_W + 1)'(asmr_pkg::GAIN_ONE / 2);
        scaled  = rounded[asmr_pkg::SAMPLE_W+asmr_pkg::GAIN_W:asmr_pkg::GAIN_FRAC];
        if (scaled > (asmr_pkg::SAMPLE_W + 2)'(32767))
            gained = 16'h7fff;
        else if (scaled < -(asmr_pkg::SAMPLE_W + 2)'(32768))
            gained = 16'h8000;
        else
            gained = scaled[asmr_pkg::SAMPLE_W-1:0];
    end

    assign item_stall = (state_reg != ST_IDLE);
    assign item_take  = item_valid && !item_stall;
    assign out_free   = !out_valid_reg || !result_stall;

    // Elapsed value seen by a flush: fade-in mirrors its position onto the fade-out.
    always_comb
    begin
        if (mode_reg == asmr_pkg::MODE_FADE_IN)
        begin
            if (elapsed_reg < asmr_pkg::ELAPSED_W'(ramp_eff))
                flush_el = asmr_pkg::ELAPSED_W'(ramp_eff) - elapsed_reg;
            else
                flush_el = '0;
        end
        else
        begin
            flush_el = elapsed_reg;
        end
        flush_sum = {1'b0, flush_el} + (asmr_pkg::ELAPSED_W + 1)'(block_eff);
        flush_sat = flush_sum[asmr_pkg::ELAPSED_W] ? asmr_pkg::ELAPSED_MAX
                                                   : flush_sum[asmr_pkg::ELAPSED_W-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        elapsed_next    = elapsed_reg;
        gain_next       = gain_reg;
        phase_next      = phase_reg;
        ptr_next        = ptr_reg;
        burst_cnt_next  = burst_cnt_reg;
        cmd_next        = cmd_reg;
        sample_next     = sample_reg;
        out_valid_next  = out_valid_reg && result_stall;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;
        out_mode_next   = out_mode_reg;
        div_req.start   = 1'b0;
        div_req.num     = '0;
        div_req.den     = ramp_eff;
        line_req.en     = 1'b0;
        line_req.addr   = '0;
        line_req.wdata  = '0;

        // A pointer left beyond a shortened ramp restarts at zero.
        addr_now    = ({1'b0, ptr_reg} >= ramp_eff) ? '0 : ptr_reg;
        addr_inc    = {1'b0, addr_now} + 1'b1;
        phase_inc   = {1'b0, phase_reg} + 1'b1;
        burst_inc   = {1'b0, burst_cnt_reg} + 1'b1;
        silence_len = asmr_pkg::ELAPSED_W'(ramp_eff) + asmr_pkg::ELAPSED_W'(extra_reg);
        step_el     = (elapsed_reg == asmr_pkg::ELAPSED_MAX) ? elapsed_reg
                                                              : elapsed_reg + 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_take)
                begin
                    cmd_next       = command;
                    sample_next    = sample_in;
                    burst_cnt_next = '0;
                    case (command)
                        asmr_pkg::CMD_SAMPLE:
                        begin
                            state_next = ST_ACCESS;
                            if (phase_reg == '0)
                            begin
                                if (mode_reg == asmr_pkg::MODE_FADE_IN)
                                begin
                                    if (elapsed_reg < asmr_pkg::ELAPSED_W'(ramp_eff))
                                    begin
                                        div_req.start = 1'b1;
                                        div_req.num   = elapsed_reg[asmr_pkg::DELAY_AW-1:0];
                                        state_next    = ST_DIV;
                                    end
                                    else
                                    begin
                                        gain_next = asmr_pkg::GAIN_W'(asmr_pkg::GAIN_ONE);
                                    end
                                end
                                else if (mode_reg == asmr_pkg::MODE_PASS)
                                begin
                                    gain_next = asmr_pkg::GAIN_W'(asmr_pkg::GAIN_ONE);
                                end
                                else
                                begin
                                    gain_next = '0;
                                end
                            end
                        end
                        asmr_pkg::CMD_FLUSH:
                        begin
                            phase_next = '0;
                            if (mode_reg == asmr_pkg::MODE_SILENCE)
                            begin
                                gain_next    = '0;
                                elapsed_next = '0;
                            end
                            else
                            begin
                                state_next = ST_ACCESS;
                                if (flush_el >= asmr_pkg::ELAPSED_W'(ramp_eff))
                                begin
                                    gain_next = '0;
                                end
                                else if (flush_el == '0)
                                begin
                                    gain_next = asmr_pkg::GAIN_W'(asmr_pkg::GAIN_ONE);
                                end
                                else
                                begin
                                    div_req.start = 1'b1;
                                    div_req.num   = asmr_pkg::DELAY_AW'(
                                        asmr_pkg::ELAPSED_W'(ramp_eff) - flush_el);
                                    state_next    = ST_DIV;
                                end
                                if (flush_sat >= asmr_pkg::ELAPSED_W'(ramp_eff))
                                begin
                                    elapsed_next = '0;
                                    mode_next    = asmr_pkg::MODE_SILENCE;
                                end
                                else
                                begin
                                    elapsed_next = flush_sat;
                                    mode_next    = asmr_pkg::MODE_FADE_OUT;
                                end
                            end
                        end
                        asmr_pkg::CMD_RESET:
                        begin
                            mode_next    = asmr_pkg::MODE_SILENCE;
                            elapsed_next = '0;
                            phase_next   = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    gain_next  = {1'b0, div_rsp.quotient};
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                // Swap the oldest entry for the new sample, or for silence on a flush.
                line_req.en    = 1'b1;
                line_req.addr  = addr_now;
                line_req.wdata = (cmd_reg == asmr_pkg::CMD_SAMPLE) ? sample_reg : '0;
                ptr_next       = (addr_inc >= ramp_eff) ? '0
                                                        : addr_inc[asmr_pkg::DELAY_AW-1:0];
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (cmd_reg == asmr_pkg::CMD_SAMPLE)
                    begin
                        out_last_next = 1'b1;
                        out_mode_next = mode_reg;
                        if (mode_reg == asmr_pkg::MODE_PASS)
                            out_sample_next = line_data;
                        else if (mode_reg == asmr_pkg::MODE_FADE_IN)
                            out_sample_next = gained;
                        else
                            out_sample_next = '0;

                        if (mode_reg != asmr_pkg::MODE_PASS)
                            elapsed_next = step_el;

                        if (phase_inc >= block_eff)
                        begin
                            phase_next = '0;
                            if (mode_reg == asmr_pkg::MODE_SILENCE ||
                                mode_reg == asmr_pkg::MODE_FADE_OUT)
                            begin
                                if (step_el >= silence_len)
                                begin
                                    mode_next    = asmr_pkg::MODE_FADE_IN;
                                    elapsed_next = '0;
                                end
                            end
                            else if (mode_reg == asmr_pkg::MODE_FADE_IN)
                            begin
                                if (step_el >= asmr_pkg::ELAPSED_W'(ramp_eff))
                                begin
                                    mode_next    = asmr_pkg::MODE_PASS;
                                    elapsed_next = '0;
                                end
                            end
                        end
                        else
                        begin
                            phase_next = phase_inc[asmr_pkg::PHASE_W-1:0];
                        end
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        out_sample_next = gained;
                        out_mode_next   = asmr_pkg::MODE_FADE_OUT;
                        out_last_next   = (burst_inc == block_eff);
                        burst_cnt_next  = burst_inc[asmr_pkg::PHASE_W-1:0];
                        state_next      = (burst_inc == block_eff) ? ST_IDLE : ST_ACCESS;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ramp_reg      <= asmr_pkg::RAMP_W'(4410);
            extra_reg     <= asmr_pkg::EXTRA_W'(4410);
            block_reg     <= asmr_pkg::BLOCK_W'(64);
            mode_reg      <= asmr_pkg::MODE_SILENCE;
            elapsed_reg   <= '0;
            gain_reg      <= '0;
            phase_reg     <= '0;
            ptr_reg       <= '0;
            burst_cnt_reg <= '0;
            cmd_reg       <= asmr_pkg::CMD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            elapsed_reg   <= elapsed_next;
            gain_reg      <= gain_next;
            phase_reg     <= phase_next;
            ptr_reg       <= ptr_next;
            burst_cnt_reg <= burst_cnt_next;
            cmd_reg       <= cmd_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    asmr_pkg::REG_RAMP:  ramp_reg  <= cfg_data[asmr_pkg::RAMP_W-1:0];
                    asmr_pkg::REG_EXTRA: extra_reg <= cfg_data[asmr_pkg::EXTRA_W-1:0];
                    asmr_pkg::REG_BLOCK: block_reg <= cfg_data[asmr_pkg::BLOCK_W-1:0];
                    default:             ramp_reg  <= ramp_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg     <= sample_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
        out_mode_reg   <= out_mode_next;
    end

    assign result_valid = out_valid_reg;
    assign sample_out   = out_sample_reg;
    assign burst_last   = out_last_reg;
    assign ramp_mode    = out_mode_reg;

    // An accepted sample always leaves the idle state for its line access.
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && command == asmr_pkg::CMD_SAMPLE |=> item_stall)
        else $error("sample transfer did not start a line access");

    // Only a non-final result of a flush burst may carry a cleared burst_last.
    a_burst_mode: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !burst_last |-> ramp_mode == asmr_pkg::MODE_FADE_OUT)
        else $error("non-final burst result outside fade-out");

    // The divider runs only while the sequencer waits for the gain.
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.busy |-> state_reg == ST_DIV)
        else $error("gain divider busy outside the divide state");

    // A line access is always followed by a cycle that can emit its result.
    a_access_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ACCESS |=> state_reg == ST_EMIT)
        else $error("line access not followed by emit");

endmodule

`default_nettype wire
